// ===== src/sltd_pkg.sv =====
package sltd_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_THIRD  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_FOURTH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TRAILER     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEAD_INFO   = 3'd6;

    localparam int unsigned CFG_DATA_BITS = 16;
    localparam int unsigned FLEN_BITS     = 16;

    // configuration seen by the deframing core
    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  sync_third;
        logic [7:0]  sync_fourth;
        logic [7:0]  trailer;
        logic [15:0] limit;
        logic [7:0]  head_info;
    } t_cfg;

endpackage

// ===== src/sltd_cfg.sv =====
module sltd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sltd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [sltd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output sltd_pkg::t_cfg                      o_cfg
);

    sltd_pkg::t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= 8'd0;
            r_cfg.sync_second <= 8'd0;
            r_cfg.sync_third  <= 8'd0;
            r_cfg.sync_fourth <= 8'd0;
            r_cfg.trailer     <= 8'd0;
            r_cfg.limit       <= 16'hFFFF;
            r_cfg.head_info   <= 8'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sltd_pkg::REG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data[7:0];
                sltd_pkg::REG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data[7:0];
                sltd_pkg::REG_SYNC_THIRD:  r_cfg.sync_third  <= i_cfg_data[7:0];
                sltd_pkg::REG_SYNC_FOURTH: r_cfg.sync_fourth <= i_cfg_data[7:0];
                sltd_pkg::REG_TRAILER:     r_cfg.trailer     <= i_cfg_data[7:0];
                sltd_pkg::REG_LIMIT:       r_cfg.limit       <= i_cfg_data[15:0];
                sltd_pkg::REG_HEAD_INFO:   r_cfg.head_info   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/sltd_core.sv =====
module sltd_core #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sltd_pkg::t_cfg                    i_cfg,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_kind,
    output logic [7:0]                        o_byte_value,
    output logic [sltd_pkg::FLEN_BITS-1:0]    o_frame_length
);

    localparam int unsigned BOUND_BITS = 18;

    // frame phase codes
    localparam logic [2:0] PH_SYNC0  = 3'd0;
    localparam logic [2:0] PH_SYNC1  = 3'd1;
    localparam logic [2:0] PH_SYNC2  = 3'd2;
    localparam logic [2:0] PH_SYNC3  = 3'd3;
    localparam logic [2:0] PH_LEN_LO = 3'd4;
    localparam logic [2:0] PH_LEN_HI = 3'd5;
    localparam logic [2:0] PH_BODY   = 3'd6;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // frame state
    logic [2:0]             r_phase, n_phase;
    logic [7:0]             r_len_lo, n_len_lo;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [LENGTH_BITS-1:0] r_last, n_last;
    logic [LENGTH_BITS-1:0] r_pay, n_pay;
    logic [LENGTH_BITS-1:0] r_count, n_count;

    // result register
    logic                          r_out_valid, n_out_valid;
    logic [1:0]                    r_kind, n_kind;
    logic [7:0]                    r_byte, n_byte;
    logic [sltd_pkg::FLEN_BITS-1:0] r_flen, n_flen;

    logic                   advance;
    logic                   step;
    logic [7:0]             want;
    logic [15:0]            len_full;
    logic [LENGTH_BITS-1:0] len_new;
    logic [BOUND_BITS-1:0]  len_wide;
    logic [BOUND_BITS-1:0]  hi_bound;
    logic [BOUND_BITS-1:0]  lo_bound;
    logic [BOUND_BITS-1:0]  pay_wide;

    // handshake: the result register frees when empty or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_data_byte;
        end
    end

    // expected sync byte for the current phase
    always_comb begin
        case (r_phase)
            PH_SYNC0: want = i_cfg.sync_first;
            PH_SYNC1: want = i_cfg.sync_second;
            PH_SYNC2: want = i_cfg.sync_third;
            default:  want = i_cfg.sync_fourth;
        endcase
    end

    // length assembly and bounds
    assign len_full = {r_in_byte, r_len_lo};
    assign len_new  = len_full[LENGTH_BITS-1:0];
    assign len_wide = BOUND_BITS'(len_new);
    assign hi_bound = BOUND_BITS'(i_cfg.limit) + BOUND_BITS'(1) + BOUND_BITS'(i_cfg.head_info);
    assign lo_bound = BOUND_BITS'(i_cfg.head_info) + BOUND_BITS'(1);
    assign pay_wide = len_wide - BOUND_BITS'(1) - BOUND_BITS'(i_cfg.head_info);

    // one deframing step
    always_comb begin
        n_phase     = r_phase;
        n_len_lo    = r_len_lo;
        n_len       = r_len;
        n_last      = r_last;
        n_pay       = r_pay;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_flen      = r_flen;
        if (step) begin
            n_out_valid = 1'b0;
            case (r_phase)
                PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
                    n_phase = (r_in_byte == want) ? r_phase + 3'd1 : PH_SYNC0;
                end
                PH_LEN_LO: begin
                    n_len_lo = r_in_byte;
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = len_new;
                    n_last  = len_new - LENGTH_BITS'(1);
                    n_pay   = pay_wide[LENGTH_BITS-1:0];
                    n_count = '0;
                    if (len_wide > hi_bound || len_wide < lo_bound) begin
                        n_phase = PH_SYNC0;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (r_count == r_last) begin
                        // tail byte closes the frame
                        n_phase     = PH_SYNC0;
                        n_out_valid = 1'b1;
                        n_kind      = (r_in_byte == i_cfg.trailer) ? sltd_pkg::KIND_ACCEPT
                                                                   : sltd_pkg::KIND_REJECT;
                        n_byte      = 8'd0;
                        n_flen      = sltd_pkg::FLEN_BITS'(r_len);
                    end else begin
                        n_count = r_count + LENGTH_BITS'(1);
                        if (r_count < r_pay) begin
                            n_out_valid = 1'b1;
                            n_kind      = sltd_pkg::KIND_PAYLOAD;
                            n_byte      = r_in_byte;
                            n_flen      = '0;
                        end
                    end
                end
                default: begin
                    n_phase = PH_SYNC0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_lo <= n_len_lo;
        r_last   <= n_last;
        r_pay    <= n_pay;
        r_count  <= n_count;
        r_kind   <= n_kind;
        r_byte   <= n_byte;
        r_flen   <= n_flen;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_byte_value   = r_byte;
    assign o_frame_length = r_flen;

    // checks
    a_payload_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == sltd_pkg::KIND_PAYLOAD) |-> (r_flen == '0))
        else $error("payload item carries a frame length");

    a_marker_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != sltd_pkg::KIND_PAYLOAD) |-> (r_byte == 8'd0))
        else $error("end marker carries a byte value");

    a_tail_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_phase == PH_BODY && r_count == r_last) |=> (r_phase == PH_SYNC0))
        else $error("hunting not restarted after tail");

    a_body_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_pay <= r_last && r_count <= r_last))
        else $error("body counters out of range");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("held result dropped");

endmodule

// ===== src/sync_length_tail_deframer.sv =====
// Byte-stream deframer: hunts for four configured sync bytes, reads a
// little-endian info length, forwards the leading payload bytes as they arrive
// and closes each frame whose length is in bounds with an accept or reject
// marker from the tail byte. One byte is taken every clock while o_in_stall
// is low. A byte accepted into the input register is handled by the deframing
// step, which puts its result in the result register. The step between the
// two registers sets that rate. A stall on the output holds the input side
// only while the result register is full and not being taken. The user must
// write configuration registers only while the block is idle; the block
// itself does not enforce this.
module sync_length_tail_deframer #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sltd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [sltd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_kind,
    output logic [7:0]                          o_byte_value,
    output logic [sltd_pkg::FLEN_BITS-1:0]      o_frame_length
);

    sltd_pkg::t_cfg cfg;

    // configuration registers
    sltd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // deframing pipeline
    sltd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_byte_value   (o_byte_value),
        .o_frame_length (o_frame_length)
    );

endmodule
